// ----- hw/rtl/bpdc_pkg.sv -----
package bpdc_pkg;

    // Curve configuration
    localparam int MAX_POINTS = 4;
    localparam int COORD_BITS = 16;
    localparam int NUM_CP     = 4;
    localparam int CP_HALF    = 16;
    localparam int CW         = (COORD_BITS < CP_HALF) ? COORD_BITS : CP_HALF;

    // Field widths
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CP_IDX_W  = $clog2(NUM_CP);
    localparam int PC_W      = 3;
    localparam int LEN_W     = 24;
    localparam int DIST_W    = 24;
    localparam int POS_W     = 24;
    localparam int FRAC_W    = 8;

    // Curve parameter t, unsigned Q1.16
    localparam int T_FRAC = 16;
    localparam int T_W    = T_FRAC + 1;
    localparam int T_ONE  = 1 << T_FRAC;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int LEVELS = MAX_POINTS - 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CP0          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CP3          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = 3'd5;

    typedef logic signed [POS_W-1:0] t_coord;
    typedef t_coord t_pts [MAX_POINTS];

    typedef struct packed {
        logic             valid;
        logic             clamped;
        logic             invalid;
        logic [CNT_W-1:0] n_pts;
    } t_ctrl;

    // Sign-extend the low CW bits of a coordinate half and scale to Q.8
    function automatic t_coord coord_of(input logic [CP_HALF-1:0] half);
        logic signed [CW-1:0] v;
        v = half[CW-1:0];
        return t_coord'(v) <<< FRAC_W;
    endfunction

endpackage

// ----- hw/rtl/bpdc_div.sv -----
module bpdc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bpdc_pkg::t_ctrl              i_ctrl,
    input  logic                         i_t_one,
    input  logic [bpdc_pkg::DIST_W-1:0]  i_dist,
    input  logic [bpdc_pkg::LEN_W-1:0]   i_len,
    output bpdc_pkg::t_ctrl              o_ctrl,
    output logic [bpdc_pkg::T_W-1:0]     o_t
);
    import bpdc_pkg::*;

    localparam int STEPS = T_FRAC;
    localparam int REM_W = LEN_W + 1;

    t_ctrl             r_ctrl [STEPS];
    logic              r_one  [STEPS];
    logic [REM_W-1:0]  r_rem  [STEPS];
    logic [T_FRAC-1:0] r_q    [STEPS];

    // One quotient bit per stage; the remainder stays below the divisor
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        t_ctrl             p_ctrl;
        logic              p_one;
        logic [REM_W-1:0]  p_rem;
        logic [T_FRAC-1:0] p_q;
        logic [REM_W-1:0]  sh;
        logic [REM_W-1:0]  n_rem;
        logic [T_FRAC-1:0] n_q;
        logic              ge;

        if (g == 0) begin : g_first
            assign p_ctrl = i_ctrl;
            assign p_one  = i_t_one;
            assign p_rem  = i_t_one ? '0 : REM_W'(i_dist);
            assign p_q    = '0;
        end else begin : g_next
            assign p_ctrl = r_ctrl[g-1];
            assign p_one  = r_one[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_q    = r_q[g-1];
        end

        always_comb begin
            sh    = {p_rem[REM_W-2:0], 1'b0};
            ge    = (sh >= REM_W'(i_len));
            n_rem = ge ? (sh - REM_W'(i_len)) : sh;
            n_q   = {p_q[T_FRAC-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[g] <= '0;
            end else begin
                r_ctrl[g] <= p_ctrl;
            end
        end

        always_ff @(posedge i_clk) begin
            r_one[g] <= p_one;
            r_rem[g] <= n_rem;
            r_q[g]   <= n_q;
        end
    end

    assign o_ctrl = r_ctrl[STEPS-1];
    assign o_t    = r_one[STEPS-1] ? T_W'(T_ONE) : T_W'(r_q[STEPS-1]);

endmodule

// ----- hw/rtl/bpdc_lerp.sv -----
module bpdc_lerp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bpdc_pkg::t_ctrl           i_ctrl,
    input  logic                      i_active,
    input  logic [bpdc_pkg::T_W-1:0]  i_t,
    input  bpdc_pkg::t_pts            i_x,
    input  bpdc_pkg::t_pts            i_y,
    output bpdc_pkg::t_ctrl           o_ctrl,
    output logic [bpdc_pkg::T_W-1:0]  o_t,
    output bpdc_pkg::t_pts            o_x,
    output bpdc_pkg::t_pts            o_y
);
    import bpdc_pkg::*;

    localparam int D_W    = POS_W + 1;
    localparam int PROD_W = T_W + 1 + D_W;
    localparam int ROUND  = 1 << (T_FRAC - 1);
    localparam int NPROD  = MAX_POINTS - 1;

    // Multiply stage
    t_ctrl                    r_m_ctrl;
    logic                     r_m_act;
    logic [T_W-1:0]           r_m_t;
    t_pts                     r_m_ax;
    t_pts                     r_m_ay;
    logic signed [PROD_W-1:0] r_m_px [NPROD];
    logic signed [PROD_W-1:0] r_m_py [NPROD];

    // Accumulate stage
    t_ctrl                    r_a_ctrl;
    logic [T_W-1:0]           r_a_t;
    t_pts                     r_a_x;
    t_pts                     r_a_y;
    t_pts                     n_x;
    t_pts                     n_y;

    logic signed [T_W:0]      t_s;

    // floor(p / 2^16 + 1/2), p = t * (b - a)
    function automatic logic signed [D_W-1:0] round_step(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] s;
        s = p + PROD_W'(ROUND);
        return $signed(s[T_FRAC +: D_W]);
    endfunction

    assign t_s = $signed({1'b0, i_t});

    for (genvar i = 0; i < NPROD; i++) begin : g_mul
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;

        always_comb begin
            dx = D_W'(i_x[i+1]) - D_W'(i_x[i]);
            dy = D_W'(i_y[i+1]) - D_W'(i_y[i]);
        end

        always_ff @(posedge i_clk) begin
            r_m_px[i] <= PROD_W'(t_s) * PROD_W'(dx);
            r_m_py[i] <= PROD_W'(t_s) * PROD_W'(dy);
        end
    end

    always_comb begin
        for (int i = 0; i < NPROD; i++) begin
            n_x[i] = r_m_act ? POS_W'(D_W'(r_m_ax[i]) + round_step(r_m_px[i])) : r_m_ax[i];
            n_y[i] = r_m_act ? POS_W'(D_W'(r_m_ay[i]) + round_step(r_m_py[i])) : r_m_ay[i];
        end
        n_x[NPROD] = r_m_ax[NPROD];
        n_y[NPROD] = r_m_ay[NPROD];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctrl <= '0;
            r_a_ctrl <= '0;
        end else begin
            r_m_ctrl <= i_ctrl;
            r_a_ctrl <= r_m_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_act <= i_active;
        r_m_t   <= i_t;
        r_m_ax  <= i_x;
        r_m_ay  <= i_y;
        r_a_t   <= r_m_t;
        r_a_x   <= n_x;
        r_a_y   <= n_y;
    end

    assign o_ctrl = r_a_ctrl;
    assign o_t    = r_a_t;
    assign o_x    = r_a_x;
    assign o_y    = r_a_y;

endmodule

// ----- hw/rtl/bezier_point_de_casteljau.sv -----
// Channel      | Ports                                      | Handshake
// -------------+--------------------------------------------+---------------------------------
// command      | i_start, o_busy, i_distance                | taken when i_start && !o_busy
// result       | o_valid, o_pos_x, o_pos_y, o_t_clamped,    | one-cycle strobe, always taken
//              | o_invalid                                  |
// config write | i_cfg_we, i_cfg_index, i_cfg_data          | written on any edge with i_cfg_we
//
// A transaction enters every cycle; o_busy is always low because nothing downstream can stall.
// The pipeline holds one entry register, one restoring-divider stage per quotient bit, a multiply
// and an accumulate stage per de Casteljau level, and the output register.
// Reset is synchronous and active low; it clears the valid bits and all configuration registers.
// Configuration is read live by the pipeline, so write it only with the pipeline empty.
module bezier_point_de_casteljau (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [bpdc_pkg::DIST_W-1:0]    i_distance,
    input  logic                           i_cfg_we,
    input  logic [bpdc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpdc_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                           o_valid,
    output logic signed [bpdc_pkg::POS_W-1:0] o_pos_x,
    output logic signed [bpdc_pkg::POS_W-1:0] o_pos_y,
    output logic                           o_t_clamped,
    output logic                           o_invalid
);
    import bpdc_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0]  r_cp [NUM_CP];
    logic [PC_W-1:0]   r_point_count;
    logic [LEN_W-1:0]  r_total_length;

    // Entry stage
    t_ctrl             r_in_ctrl;
    logic              r_in_t_one;
    logic [DIST_W-1:0] r_in_dist;
    t_ctrl             n_in_ctrl;
    logic [CNT_W-1:0]  n_pts;

    // De Casteljau level buses; index 0 is the divider output
    t_ctrl             lvl_ctrl [LEVELS+1];
    logic [T_W-1:0]    lvl_t    [LEVELS+1];
    t_pts              lvl_x    [LEVELS+1];
    t_pts              lvl_y    [LEVELS+1];

    // Output register
    logic              r_out_valid;
    t_coord            r_pos_x;
    t_coord            r_pos_y;
    logic              r_t_clamped;
    logic              r_invalid;

    // Never stall: every level is a fixed-latency stage
    assign o_busy = 1'b0;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CP; i++) begin
                r_cp[i] <= '0;
            end
            r_point_count  <= '0;
            r_total_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index) inside
                [REG_CP0:REG_CP3]: r_cp[i_cfg_index[CP_IDX_W-1:0]] <= i_cfg_data;
                REG_POINT_COUNT:   r_point_count  <= i_cfg_data[PC_W-1:0];
                REG_TOTAL_LENGTH:  r_total_length <= i_cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Entry: cap the point count, decide clamp and error up front
    always_comb begin
        n_pts = (r_point_count > PC_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                     : CNT_W'(r_point_count);
        n_in_ctrl.valid   = i_start && !o_busy;
        n_in_ctrl.n_pts   = n_pts;
        n_in_ctrl.invalid = (n_pts == '0) || (r_total_length == '0);
        n_in_ctrl.clamped = !n_in_ctrl.invalid && (i_distance > r_total_length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctrl <= '0;
        end else begin
            r_in_ctrl <= n_in_ctrl;
        end
    end

    // Hold distance >= length as t = 1.0; the divider then only sees dist < len
    always_ff @(posedge i_clk) begin
        r_in_dist  <= i_distance;
        r_in_t_one <= (i_distance >= r_total_length);
    end

    // t = floor(distance * 2^16 / length)
    bpdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_in_ctrl),
        .i_t_one (r_in_t_one),
        .i_dist  (r_in_dist),
        .i_len   (r_total_length),
        .o_ctrl  (lvl_ctrl[0]),
        .o_t     (lvl_t[0])
    );

    // Control points in Q.8, straight from the configuration
    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            lvl_x[0][i] = coord_of(r_cp[i][CP_HALF-1:0]);
            lvl_y[0][i] = coord_of(r_cp[i][CFG_W-1:CP_HALF]);
        end
    end

    // Level g interpolates only when more than g + 1 points are in use; otherwise pass through
    for (genvar g = 0; g < LEVELS; g++) begin : g_level
        logic active;

        assign active = (lvl_ctrl[g].n_pts > CNT_W'(g + 1));

        bpdc_lerp u_lerp (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (lvl_ctrl[g]),
            .i_active (active),
            .i_t      (lvl_t[g]),
            .i_x      (lvl_x[g]),
            .i_y      (lvl_y[g]),
            .o_ctrl   (lvl_ctrl[g+1]),
            .o_t      (lvl_t[g+1]),
            .o_x      (lvl_x[g+1]),
            .o_y      (lvl_y[g+1])
        );
    end

    // Result register; force zero position on error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= lvl_ctrl[LEVELS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_x     <= lvl_ctrl[LEVELS].invalid ? '0 : lvl_x[LEVELS][0];
        r_pos_y     <= lvl_ctrl[LEVELS].invalid ? '0 : lvl_y[LEVELS][0];
        r_t_clamped <= lvl_ctrl[LEVELS].clamped;
        r_invalid   <= lvl_ctrl[LEVELS].invalid;
    end

    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_t_clamped = r_t_clamped;
    assign o_invalid   = r_invalid;

endmodule

// ----- sim/bezier_point_de_casteljau_tb.sv -----
module bezier_point_de_casteljau_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpdc_pkg::*;

    // Pipeline depth with the full four-point evaluation
    localparam int LATENCY        = 2 + T_FRAC + 2 * LEVELS;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SEG_ITEMS      = 46;
    localparam int SEGS_PER_PHASE = 4;

    // Indexes past the last register; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // Extreme 16-bit coordinates scaled to Q16.8
    localparam logic signed [POS_W-1:0] Q8_MAX = 24'sh7FFF00;
    localparam logic signed [POS_W-1:0] Q8_MIN = 24'sh800000;

    typedef struct packed {
        logic [NUM_CP-1:0][CFG_W-1:0] cp;
        logic [PC_W-1:0]              count;
        logic [LEN_W-1:0]             length;
    } t_curve_cfg;

    typedef struct packed {
        logic [DIST_W-1:0]       travel;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    clamped;
        logic                    invalid;
    } t_curve_point;

    typedef struct packed {
        t_curve_cfg        cfg;
        logic [DIST_W-1:0] travel;
        logic              typed;
        t_curve_point      want;
    } t_stim_row;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_start     = 1'b0;
    logic [DIST_W-1:0]       i_distance  = '0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data  = '0;
    logic                    o_busy;
    logic                    o_valid;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic                    o_t_clamped;
    logic                    o_invalid;

    // Curve setting currently loaded in the block, and points still in flight
    t_curve_cfg   live_cfg = '0;
    t_curve_point pending_points[$];

    int idle_pct         = 0;
    int fail_count       = 0;
    int points_sent      = 0;
    int points_checked   = 0;
    int clamp_seen       = 0;
    int invalid_seen     = 0;
    int settings_applied = 0;
    int cycle_count      = 0;

    bezier_point_de_casteljau uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_distance  (i_distance),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_t_clamped (o_t_clamped),
        .o_invalid   (o_invalid)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Curve evaluation
    // ------------------------------------------------------------------

    // Sign-extend the used coordinate bits and move them to Q.8
    function automatic longint q8_coord(input logic [CP_HALF-1:0] half);
        logic signed [CW-1:0] c;
        c = half[CW-1:0];
        return longint'(c) * 256;
    endfunction

    // One linear step between a and b at t (Q1.16), rounding half up;
    // the arithmetic shift of the signed sum is the floor division
    function automatic longint blend(input longint a, input longint b, input longint t);
        return ((T_ONE - t) * a + t * b + 32768) >>> T_FRAC;
    endfunction

    function automatic logic signed [POS_W-1:0] clip24(input longint v);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[POS_W-1:0];
    endfunction

    function automatic t_curve_point predict_point(input t_curve_cfg cfg,
                                                   input logic [DIST_W-1:0] travel);
        t_curve_point r;
        longint       px[NUM_CP];
        longint       py[NUM_CP];
        longint       t;
        int           n;
        int           i;
        int           k;
        r = '0;
        r.travel = travel;
        n = (cfg.count > MAX_POINTS) ? MAX_POINTS : int'(cfg.count);
        // No points or no length: zero position, error flag only
        if (n == 0 || cfg.length == '0) begin
            r.invalid = 1'b1;
            return r;
        end
        // Past the end of the curve: hold t at 1.0 and flag the clamp
        if (travel > cfg.length) begin
            t = T_ONE;
            r.clamped = 1'b1;
        end else begin
            t = (longint'(travel) << T_FRAC) / longint'(cfg.length);
            if (t > T_ONE) t = T_ONE;
        end
        for (i = 0; i < n; i++) begin
            px[i] = q8_coord(cfg.cp[i][CP_HALF-1:0]);
            py[i] = q8_coord(cfg.cp[i][CFG_W-1:CP_HALF]);
        end
        // Collapse neighbors level by level until one point remains
        for (k = 1; k < n; k++) begin
            for (i = 0; i + k < n; i++) begin
                px[i] = blend(px[i], px[i + 1], t);
                py[i] = blend(py[i], py[i + 1], t);
            end
        end
        r.x = clip24(px[0]);
        r.y = clip24(py[0]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    function automatic t_curve_cfg make_curve(input logic [CFG_W-1:0] cp0, cp1, cp2, cp3,
                                              input logic [PC_W-1:0] count,
                                              input logic [LEN_W-1:0] length);
        t_curve_cfg c;
        c.cp[0]  = cp0;
        c.cp[1]  = cp1;
        c.cp[2]  = cp2;
        c.cp[3]  = cp3;
        c.count  = count;
        c.length = length;
        return c;
    endfunction

    function automatic t_stim_row make_row(input t_curve_cfg cfg,
                                           input logic [DIST_W-1:0] travel,
                                           input logic typed,
                                           input logic signed [POS_W-1:0] x, y,
                                           input logic clamped, invalid);
        t_stim_row r;
        r.cfg          = cfg;
        r.travel       = travel;
        r.typed        = typed;
        r.want.travel  = travel;
        r.want.x       = x;
        r.want.y       = y;
        r.want.clamped = clamped;
        r.want.invalid = invalid;
        return r;
    endfunction

    function automatic t_curve_cfg rand_curve();
        t_curve_cfg c;
        int         r;
        int         i;
        for (i = 0; i < NUM_CP; i++) begin
            c.cp[i] = $urandom;
            // Now and then pin both halves to the coordinate extremes
            if ($urandom_range(7, 0) == 0)
                c.cp[i] = {$urandom_range(1, 0) ? 16'h7FFF : 16'h8000,
                           $urandom_range(1, 0) ? 16'h7FFF : 16'h8000};
        end
        // Mostly cubic curves, some lower orders, a few empty or oversized counts
        r = $urandom_range(19, 0);
        if (r == 0)       c.count = 3'd0;
        else if (r <= 2)  c.count = 3'd1;
        else if (r <= 4)  c.count = 3'd2;
        else if (r <= 6)  c.count = 3'd3;
        else if (r <= 16) c.count = 3'd4;
        else              c.count = PC_W'(r - 12);
        r = $urandom_range(15, 0);
        if (r == 0)       c.length = '0;
        else if (r <= 3)  c.length = LEN_W'($urandom_range(255, 1));
        else if (r <= 8)  c.length = LEN_W'($urandom_range(65535, 256));
        else if (r <= 13) c.length = LEN_W'($urandom);
        else              c.length = '1;
        return c;
    endfunction

    // Mostly distances along the curve, plus its ends and arbitrary overshoot
    function automatic logic [DIST_W-1:0] rand_distance(input logic [LEN_W-1:0] len);
        int unsigned r;
        r = $urandom_range(15, 0);
        if (r < 10 && len != '0) return DIST_W'($urandom_range(len, 0));
        if (r == 10) return '0;
        if (r == 11) return len;
        if (r == 12) return (len == '1) ? len : len + 1'b1;
        return DIST_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Load a new curve; the block reads its registers live, so drain first
    task automatic apply_curve(input t_curve_cfg cfg);
        int i;
        i_start <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, $urandom);
        for (i = 0; i < NUM_CP; i++)
            write_reg(CFG_IDX_W'(int'(REG_CP0) + i), cfg.cp[i]);
        write_reg(REG_POINT_COUNT, CFG_W'(cfg.count));
        write_reg(REG_TOTAL_LENGTH, CFG_W'(cfg.length));
        i_cfg_we <= 1'b0;
        live_cfg = cfg;
        settings_applied++;
    endtask

    // Offer one distance, hold it until the block takes the transaction,
    // then queue the point it must produce
    task automatic send_distance(input logic [DIST_W-1:0] travel, input logic typed,
                                 input t_curve_point want);
        t_curve_point exp_pt;
        while ($urandom_range(99, 0) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_distance <= travel;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        exp_pt = typed ? want : predict_point(live_cfg, travel);
        pending_points.push_back(exp_pt);
        points_sent++;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_field(input string field, input logic [DIST_W-1:0] travel,
                                input logic [POS_W-1:0] exp_v, input logic [POS_W-1:0] act_v);
        $display("%0t ns: %s mismatch for distance 0x%06h: expected 0x%06h, got 0x%06h",
                 $time, field, travel, exp_v, act_v);
        fail_count++;
    endtask

    // Sample on the edge that ends the strobe cycle; each result is seen once
    always @(posedge i_clk) begin
        t_curve_point want;
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                if (pending_points.size() == 0) begin
                    $display("%0t ns: unexpected result: expected none, got x=0x%06h y=0x%06h",
                             $time, o_pos_x, o_pos_y);
                    fail_count++;
                end else begin
                    want = pending_points.pop_front();
                    if (o_pos_x !== want.x)
                        report_field("pos_x", want.travel, want.x, o_pos_x);
                    if (o_pos_y !== want.y)
                        report_field("pos_y", want.travel, want.y, o_pos_y);
                    if (o_t_clamped !== want.clamped)
                        report_field("t_clamped", want.travel, POS_W'(want.clamped),
                                     POS_W'(o_t_clamped));
                    if (o_invalid !== want.invalid)
                        report_field("invalid", want.travel, POS_W'(want.invalid),
                                     POS_W'(o_invalid));
                    points_checked++;
                    if (want.clamped) clamp_seen++;
                    if (want.invalid) invalid_seen++;
                end
            end else if (o_valid !== 1'b0) begin
                $display("%0t ns: result strobe unknown: expected 0 or 1, got %b",
                         $time, o_valid);
                fail_count++;
            end
        end
    end

    // Watchdog: stop a run that hangs on a handshake
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles with %0d points outstanding",
                     $time, cycle_count, pending_points.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        t_stim_row  dir_rows[$];
        t_curve_cfg c_one_len0;
        t_curve_cfg c_none;
        t_curve_cfg c_one;
        t_curve_cfg c_line;
        t_curve_cfg c_cubic;
        t_curve_cfg c_cubic_len1;
        int         ph;
        int         seg;

        c_one_len0   = make_curve(32'h8000_7FFF, '0, '0, '0, 3'd1, 24'h000000);
        c_none       = make_curve(32'h1234_5678, 32'h9ABC_DEF0, '0, '0, 3'd0, 24'h000100);
        c_one        = make_curve(32'h8000_7FFF, '0, '0, '0, 3'd1, 24'h000100);
        c_line       = make_curve(32'h7FFF_8000, 32'h8000_7FFF, '0, '0, 3'd2, 24'h000100);
        c_cubic      = make_curve(32'h8000_8000, 32'h7FFF_7FFF, 32'h8000_7FFF, 32'h7FFF_8000,
                                  3'd4, 24'hFFFFFF);
        c_cubic_len1 = c_cubic;
        c_cubic_len1.length = 24'h000001;

        // Registers as left by reset: no points, no length
        dir_rows.push_back(make_row('0, 24'h000000, 1'b1, '0, '0, 1'b0, 1'b1));
        dir_rows.push_back(make_row('0, 24'hFFFFFF, 1'b1, '0, '0, 1'b0, 1'b1));
        // One point but zero length, then a length but no points
        dir_rows.push_back(make_row(c_one_len0, 24'h000080, 1'b1, '0, '0, 1'b0, 1'b1));
        dir_rows.push_back(make_row(c_none, 24'h000FFF, 1'b1, '0, '0, 1'b0, 1'b1));
        // Single point comes back as is; clamp still reported
        dir_rows.push_back(make_row(c_one, 24'h000000, 1'b1, Q8_MAX, Q8_MIN, 1'b0, 1'b0));
        dir_rows.push_back(make_row(c_one, 24'h000100, 1'b1, Q8_MAX, Q8_MIN, 1'b0, 1'b0));
        dir_rows.push_back(make_row(c_one, 24'hFFFFFF, 1'b1, Q8_MAX, Q8_MIN, 1'b1, 1'b0));
        // Straight line between opposite corners: start, exact end, overshoot, two midpoints
        dir_rows.push_back(make_row(c_line, 24'h000000, 1'b1, Q8_MIN, Q8_MAX, 1'b0, 1'b0));
        dir_rows.push_back(make_row(c_line, 24'h000100, 1'b1, Q8_MAX, Q8_MIN, 1'b0, 1'b0));
        dir_rows.push_back(make_row(c_line, 24'h000101, 1'b1, Q8_MAX, Q8_MIN, 1'b1, 1'b0));
        dir_rows.push_back(make_row(c_line, 24'h000080, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(make_row(c_line, 24'h00007F, 1'b0, '0, '0, 1'b0, 1'b0));
        // Cubic over extreme corners with the longest length
        dir_rows.push_back(make_row(c_cubic, 24'h000000, 1'b1, Q8_MIN, Q8_MIN, 1'b0, 1'b0));
        dir_rows.push_back(make_row(c_cubic, 24'hFFFFFF, 1'b1, Q8_MIN, Q8_MAX, 1'b0, 1'b0));
        dir_rows.push_back(make_row(c_cubic, 24'h000001, 1'b1, Q8_MIN, Q8_MIN, 1'b0, 1'b0));
        dir_rows.push_back(make_row(c_cubic, 24'h800000, 1'b0, '0, '0, 1'b0, 1'b0));
        // Same cubic with the shortest length
        dir_rows.push_back(make_row(c_cubic_len1, 24'h000000, 1'b1, Q8_MIN, Q8_MIN,
                                    1'b0, 1'b0));
        dir_rows.push_back(make_row(c_cubic_len1, 24'h000001, 1'b1, Q8_MIN, Q8_MAX,
                                    1'b0, 1'b0));
        dir_rows.push_back(make_row(c_cubic_len1, 24'h000002, 1'b1, Q8_MIN, Q8_MAX,
                                    1'b1, 1'b0));
        // Counts above the maximum fall back to four points; then a quadratic
        dir_rows.push_back(make_row(make_curve(32'h1234_ABCD, 32'hF00D_0FF0, 32'h0001_FFFF,
                                               32'hC3A5_5A3C, 3'd7, 24'h001000),
                                    24'h000800, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(make_row(make_curve(32'h1234_ABCD, 32'hF00D_0FF0, 32'h0001_FFFF,
                                               32'hC3A5_5A3C, 3'd5, 24'h001000),
                                    24'h000C00, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(make_row(make_curve(32'h1234_ABCD, 32'hF00D_0FF0, 32'h0001_FFFF,
                                               32'hC3A5_5A3C, 3'd6, 24'h001000),
                                    24'h000001, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_rows.push_back(make_row(make_curve(32'h1234_ABCD, 32'hF00D_0FF0, 32'h0001_FFFF,
                                               32'hC3A5_5A3C, 3'd3, 24'h001000),
                                    24'h000555, 1'b0, '0, '0, 1'b0, 1'b0));
        // Full cubic but zero length: error wins over the clamp
        dir_rows.push_back(make_row(make_curve(32'h8000_8000, 32'h7FFF_7FFF, 32'h8000_7FFF,
                                               32'h7FFF_8000, 3'd4, 24'h000000),
                                    24'hFFFFFF, 1'b1, '0, '0, 1'b0, 1'b1));

        // Hold reset at the start, then release it for good
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows back to back; reload registers only when the row's curve changes
        foreach (dir_rows[j]) begin
            if (dir_rows[j].cfg != live_cfg)
                apply_curve(dir_rows[j].cfg);
            send_distance(dir_rows[j].travel, dir_rows[j].typed, dir_rows[j].want);
        end

        // Random curves: moderate sender gaps, then heavy gaps, then full rate
        for (ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 28 : (ph == 1) ? 62 : 0;
            for (seg = 0; seg < SEGS_PER_PHASE; seg++) begin
                apply_curve(rand_curve());
                repeat (SEG_ITEMS)
                    send_distance(rand_distance(live_cfg.length), 1'b0, '0);
            end
        end

        // Drop start, wait for every point, then watch for stray strobes
        i_start <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Evaluated %0d distances over %0d curve settings, %0d results checked.",
                 points_sent, settings_applied, points_checked);
        $display("Of these %0d ran past the curve end and %0d hit an empty or zero-length curve.",
                 clamp_seen, invalid_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
